/* hdl/crst_pkg.sv */
package crst_pkg;

  localparam int CoordW = 32;
  localparam int CfgW   = 6;
  // Widest Catmull-Rom basis coefficient (2p0 - 5p1 + 4p2 - p3) needs 36 bits.
  localparam int CoefW  = 36;

  localparam logic [CfgW-1:0] SAMPLES_RESET = 6'd8;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [2:0]             point_t;
  typedef logic signed [CoefW-1:0]  coef_t;

endpackage

/* hdl/crst_pt_if.sv */
interface crst_pt_if;
  import crst_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   final_point;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output final_point, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input final_point, output ready);

endinterface

/* hdl/crst_vtx_if.sv */
interface crst_vtx_if;
  import crst_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   run_end;
  logic   curve_end;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output run_end, output curve_end, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input run_end, input curve_end, output ready);

endinterface

/* hdl/catmull_rom_spline_tessellator_unit.sv */
// Uniform Catmull-Rom tessellator. Control points come in on pt_i, one word
// per point in signed Q16.16, with final_point set on the last point of a
// curve. Curve vertices leave on vtx_o; run_end marks the last vertex caused
// by a point and curve_end the last vertex of the curve. The first point of a
// curve is passed straight through unless final, the second emits a segment
// only if final, and each later point emits one segment of n vertices (n from
// the samples register, clamped to 2..MAX_SAMPLES); a final point among these
// also emits a second, closing segment. pt_i.ready is high only while the
// block is idle. A segment first forms its coefficients, then per vertex the
// weights and per axis the multiply-accumulate terms and a 52-step restoring
// divide by 2n^3 in the one shared divider, which sets the pace. A stalled
// receiver holds the vertex in the output register and the sequencer waits
// before loading the next one; nothing is dropped. Reset empties the point
// window, clears the output valid flag and sets the samples register to 8.
// cfg_wdata_i is written while cfg_we_i is high.
module catmull_rom_spline_tessellator_unit #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [crst_pkg::CfgW-1:0]    cfg_wdata_i,
  crst_pt_if.sink                      pt_i,
  crst_vtx_if.source                   vtx_o
);
  import crst_pkg::*;

  localparam int N_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SQ_W  = $clog2(MAX_SAMPLES * MAX_SAMPLES + 1);
  localparam int CU_W  = $clog2(MAX_SAMPLES * MAX_SAMPLES * MAX_SAMPLES + 1);
  localparam int DEN_W = $clog2(2 * MAX_SAMPLES * MAX_SAMPLES * MAX_SAMPLES + 1);
  localparam int NUM_W = CoefW + DEN_W;

  localparam logic [2:0] TERM_CUBE = 3'd0;
  localparam logic [2:0] TERM_SQR  = 3'd1;
  localparam logic [2:0] TERM_LIN  = 3'd2;
  localparam logic [2:0] TERM_BASE = 3'd3;
  localparam logic [2:0] TERM_DONE = 3'd4;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_PASS   = 10'b00_0000_0010,
    ST_COEF   = 10'b00_0000_0100,
    ST_WGT1   = 10'b00_0000_1000,
    ST_WGT2   = 10'b00_0001_0000,
    ST_MUL    = 10'b00_0010_0000,
    ST_DSTART = 10'b00_0100_0000,
    ST_DWAIT  = 10'b00_1000_0000,
    ST_PUSH   = 10'b01_0000_0000,
    ST_UPDATE = 10'b10_0000_0000
  } state_e;

  // Which control points feed the first segment of a point.
  typedef enum logic [1:0] {
    KIND_TWO  = 2'd0,
    KIND_HEAD = 2'd1,
    KIND_BODY = 2'd2
  } kind_e;

  state_e            state_q, state_d;
  kind_e             kind_q;
  logic [CfgW-1:0]   samples_q;
  logic [1:0]        seen_q;
  point_t            win_q [3];
  point_t            inp_q;
  logic              fin_q;
  logic [N_W-1:0]    n_q;
  logic [N_W-1:0]    i_q;
  logic [1:0]        ax_q;
  logic [2:0]        k_q;
  logic              seg_idx_q;
  logic              seg_last_q;

  coef_t             coef_a_q [3];
  coef_t             coef_b_q [3];
  coef_t             coef_c_q [3];
  coord_t            p1_q     [3];
  logic [SQ_W-1:0]   ii_q, in_q, nn_q;
  logic [CU_W-1:0]   w3_q, w2_q, w1_q, n3_q;
  logic signed [NUM_W-1:0] prod_q;
  logic signed [NUM_W-1:0] acc_q;
  coord_t            res_q [3];

  logic              out_valid_q;
  coord_t            out_x_q, out_y_q, out_z_q;
  logic              out_run_q, out_curve_q;

  logic              in_fire;
  logic              slot_free;
  logic [N_W-1:0]    n_clamp;
  logic [DEN_W-1:0]  den;
  point_t            sel0, sel1, sel2, sel3;
  coef_t             e0, e1, e2, e3, d12;
  coef_t             mul_coef;
  logic [DEN_W-1:0]  mul_wgt;
  logic signed [NUM_W:0] prod_full;
  logic              div_done;
  coord_t            div_quot;
  logic              last_vtx;

  assign in_fire   = pt_i.valid && pt_i.ready;
  assign pt_i.ready = (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || vtx_o.ready;
  assign den       = DEN_W'({n3_q, 1'b0});
  assign last_vtx  = (i_q == n_q) && seg_last_q;

  always_comb begin
    if (samples_q < CfgW'(2)) begin
      n_clamp = N_W'(2);
    end else if (int'(samples_q) > MAX_SAMPLES) begin
      n_clamp = N_W'(MAX_SAMPLES);
    end else begin
      n_clamp = N_W'(samples_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= SAMPLES_RESET;
    end else if (cfg_we_i) begin
      samples_q <= cfg_wdata_i;
    end
  end

  // Control points of the segment being evaluated.
  always_comb begin
    sel0 = win_q[1];
    sel1 = win_q[1];
    sel2 = win_q[2];
    sel3 = inp_q;
    if (seg_idx_q) begin
      sel0 = win_q[1];
      sel1 = win_q[2];
      sel2 = inp_q;
      sel3 = inp_q;
    end else begin
      case (kind_q)
        KIND_TWO: begin
          sel0 = win_q[2];
          sel1 = win_q[2];
          sel2 = inp_q;
          sel3 = inp_q;
        end
        KIND_BODY: begin
          sel0 = win_q[0];
          sel1 = win_q[1];
          sel2 = win_q[2];
          sel3 = inp_q;
        end
        default: begin
          sel0 = win_q[1];
          sel1 = win_q[1];
          sel2 = win_q[2];
          sel3 = inp_q;
        end
      endcase
    end
  end

  assign e0  = coef_t'($signed(sel0[ax_q]));
  assign e1  = coef_t'($signed(sel1[ax_q]));
  assign e2  = coef_t'($signed(sel2[ax_q]));
  assign e3  = coef_t'($signed(sel3[ax_q]));
  assign d12 = e1 - e2;

  // Numerator terms: c*i^3 + b*i^2*n + a*i*n^2 + p1*2n^3, plus n^3 for rounding.
  always_comb begin
    case (k_q)
      TERM_CUBE: begin
        mul_coef = coef_c_q[ax_q];
        mul_wgt  = DEN_W'(w3_q);
      end
      TERM_SQR: begin
        mul_coef = coef_b_q[ax_q];
        mul_wgt  = DEN_W'(w2_q);
      end
      TERM_LIN: begin
        mul_coef = coef_a_q[ax_q];
        mul_wgt  = DEN_W'(w1_q);
      end
      TERM_BASE: begin
        mul_coef = coef_t'($signed(p1_q[ax_q]));
        mul_wgt  = den;
      end
      default: begin
        mul_coef = '0;
        mul_wgt  = '0;
      end
    endcase
  end

  assign prod_full = mul_coef * $signed({1'b0, mul_wgt});

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (seen_q == 2'd0) begin
            state_d = pt_i.final_point ? ST_UPDATE : ST_PASS;
          end else if (seen_q == 2'd1) begin
            state_d = pt_i.final_point ? ST_COEF : ST_UPDATE;
          end else begin
            state_d = ST_COEF;
          end
        end
      end
      ST_PASS:   state_d = slot_free ? ST_UPDATE : ST_PASS;
      ST_COEF:   state_d = (ax_q == 2'd2) ? ST_WGT1 : ST_COEF;
      ST_WGT1:   state_d = ST_WGT2;
      ST_WGT2:   state_d = ST_MUL;
      ST_MUL:    state_d = (k_q == TERM_DONE) ? ST_DSTART : ST_MUL;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_d = (ax_q == 2'd2) ? ST_PUSH : ST_MUL;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          if (i_q != n_q) begin
            state_d = ST_WGT1;
          end else begin
            state_d = seg_last_q ? ST_UPDATE : ST_COEF;
          end
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kind_q     <= KIND_TWO;
      seen_q     <= 2'd0;
      fin_q      <= 1'b0;
      n_q        <= N_W'(2);
      i_q        <= N_W'(1);
      ax_q       <= 2'd0;
      k_q        <= TERM_CUBE;
      seg_idx_q  <= 1'b0;
      seg_last_q <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        win_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            fin_q      <= pt_i.final_point;
            n_q        <= n_clamp;
            ax_q       <= 2'd0;
            k_q        <= TERM_CUBE;
            seg_idx_q  <= 1'b0;
            if (seen_q == 2'd1) begin
              kind_q     <= KIND_TWO;
              seg_last_q <= 1'b1;
            end else begin
              kind_q     <= (seen_q == 2'd3) ? KIND_BODY : KIND_HEAD;
              seg_last_q <= !pt_i.final_point;
            end
          end
        end
        ST_COEF: begin
          ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
          i_q  <= N_W'(1);
        end
        ST_MUL: begin
          k_q <= (k_q == TERM_DONE) ? TERM_CUBE : k_q + 3'd1;
        end
        ST_DWAIT: begin
          if (div_done) begin
            ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
          end
        end
        ST_PUSH: begin
          if (slot_free) begin
            if (i_q != n_q) begin
              i_q <= i_q + 1'b1;
            end else if (!seg_last_q) begin
              seg_idx_q  <= 1'b1;
              seg_last_q <= 1'b1;
            end
          end
        end
        ST_UPDATE: begin
          if (fin_q) begin
            for (int j = 0; j < 3; j++) begin
              win_q[j] <= '0;
            end
            seen_q <= 2'd0;
          end else begin
            win_q[0] <= win_q[1];
            win_q[1] <= win_q[2];
            win_q[2] <= inp_q;
            seen_q   <= (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inp_q <= {pt_i.point_z, pt_i.point_y, pt_i.point_x};
    end
    if (state_q == ST_COEF) begin
      coef_a_q[ax_q] <= e2 - e0;
      coef_b_q[ax_q] <= (e0 <<< 1) + (e2 <<< 2) - (e1 <<< 2) - e1 - e3;
      coef_c_q[ax_q] <= (d12 <<< 1) + d12 + (e3 - e0);
      p1_q[ax_q]     <= sel1[ax_q];
    end
    if (state_q == ST_WGT1) begin
      ii_q <= SQ_W'(i_q) * SQ_W'(i_q);
      in_q <= SQ_W'(i_q) * SQ_W'(n_q);
      nn_q <= SQ_W'(n_q) * SQ_W'(n_q);
    end
    if (state_q == ST_WGT2) begin
      w3_q <= CU_W'(ii_q) * CU_W'(i_q);
      w2_q <= CU_W'(in_q) * CU_W'(i_q);
      w1_q <= CU_W'(in_q) * CU_W'(n_q);
      n3_q <= CU_W'(nn_q) * CU_W'(n_q);
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_full[NUM_W-1:0];
      if (k_q == TERM_CUBE) begin
        acc_q <= $signed(NUM_W'(n3_q));
      end else begin
        acc_q <= acc_q + prod_q;
      end
    end
    if ((state_q == ST_DWAIT) && div_done) begin
      res_q[ax_q] <= div_quot;
    end
  end

  crst_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DSTART),
    .num_i   (acc_q),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Output register: a word waits here while the sequencer moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (((state_q == ST_PASS) || (state_q == ST_PUSH)) && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (vtx_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_PASS) && slot_free) begin
      out_x_q     <= inp_q[0];
      out_y_q     <= inp_q[1];
      out_z_q     <= inp_q[2];
      out_run_q   <= 1'b1;
      out_curve_q <= 1'b0;
    end else if ((state_q == ST_PUSH) && slot_free) begin
      out_x_q     <= res_q[0];
      out_y_q     <= res_q[1];
      out_z_q     <= res_q[2];
      out_run_q   <= last_vtx;
      out_curve_q <= last_vtx && fin_q;
    end
  end

  assign vtx_o.valid     = out_valid_q;
  assign vtx_o.out_x     = out_x_q;
  assign vtx_o.out_y     = out_y_q;
  assign vtx_o.out_z     = out_z_q;
  assign vtx_o.run_end   = out_run_q;
  assign vtx_o.curve_end = out_curve_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DWAIT)
    else $error("divider finished outside the wait state");

  a_curve_end_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vtx_o.valid && vtx_o.curve_end) |-> vtx_o.run_end)
    else $error("curve end flagged on a word that does not end its run");

  a_sample_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> ((i_q >= N_W'(1)) && (i_q <= n_q)
                              && (n_q >= N_W'(2)) && (int'(n_q) <= MAX_SAMPLES)))
    else $error("sample index or sample count out of range");

  a_first_point_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (seen_q == 2'd0) && !pt_i.final_point) |=> state_q == ST_PASS)
    else $error("first point of a curve not passed through");

endmodule

/* hdl/crst_div.sv */
module crst_div #(
  parameter int NUM_W = 53,
  parameter int DEN_W = 17
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic        [DEN_W-1:0] den_i,
  output logic                    done_o,
  output crst_pkg::coord_t        quot_o
);
  import crst_pkg::*;

  localparam int MAG_W = NUM_W - 1;
  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [MAG_W:0] POS_LIM = (MAG_W+1)'(2147483647);
  localparam logic [MAG_W:0] NEG_LIM = POS_LIM + 1'b1;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [MAG_W-1:0] dvd_q;

  logic [NUM_W-1:0] num_abs;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;
  logic [MAG_W:0]   qmag;
  logic [MAG_W:0]   qneg;

  assign num_abs = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign trial   = {rem_q, dvd_q[MAG_W-1]};
  assign diff    = trial - {1'b0, den_q};
  assign take    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MAG_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division on the magnitude, one quotient bit a cycle; the
  // quotient shifts in behind the dividend bits as they are consumed.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      den_q <= den_i;
      rem_q <= '0;
      dvd_q <= num_abs[MAG_W-1:0];
    end else if (busy_q) begin
      rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dvd_q <= {dvd_q[MAG_W-2:0], take};
    end
  end

  // Floor division: a negative dividend with a remainder rounds one further down.
  assign qmag = {1'b0, dvd_q} + (MAG_W+1)'(neg_q && (rem_q != '0));
  assign qneg = -qmag;

  always_comb begin
    if (!neg_q) begin
      quot_o = (qmag > POS_LIM) ? coord_t'(32'sh7FFF_FFFF) : coord_t'(qmag[CoordW-1:0]);
    end else begin
      quot_o = (qmag > NEG_LIM) ? coord_t'(32'sh8000_0000) : coord_t'(qneg[CoordW-1:0]);
    end
  end

  assign done_o = done_q;

endmodule

/* bench/tb.sv */
module tb;
  import crst_pkg::*;

  localparam int     MAX_SEG_SAMPLES = 32;
  localparam int     SETTLE_CYCLES   = 200;
  localparam int     DRAIN_CYCLES    = 400;
  localparam int     HOLD_OFF_CYCLES = 600;
  localparam int     WATCHDOG_LIMIT  = 6000;
  localparam coord_t COORD_MAX       = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN       = 32'sh8000_0000;

  typedef coord_t xyz_t [3];

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   run_end;
    logic   curve_end;
  } vertex_t;

  class spline_scoreboard;
    xyz_t            window_pts [3];
    int              points_seen;
    logic [CfgW-1:0] samples;
    vertex_t         expected_vertices [$];
    int              mismatches;
    int              vertices_checked;

    function new();
      clear_window();
      samples          = SAMPLES_RESET;
      mismatches       = 0;
      vertices_checked = 0;
    endfunction

    function void clear_window();
      int j;
      for (j = 0; j < 3; j++) begin
        window_pts[j] = '{0, 0, 0};
      end
      points_seen = 0;
    endfunction

    function void set_samples(logic [CfgW-1:0] value);
      samples = value;
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction

    function void enqueue_vertex(vertex_t v);
      expected_vertices.insert(expected_vertices.size(), v);
    endfunction

    function coord_t saturate(longint v);
      if (v > 64'sd2147483647) return COORD_MAX;
      if (v < -64'sd2147483648) return COORD_MIN;
      return coord_t'(v);
    endfunction

    // Exact cubic over the common denominator 2n^3, rounded half up.
    function coord_t spline_coord(longint p0, longint p1, longint p2, longint p3,
                                  longint i, longint n);
      longint n3, a, b, c, num, den, x, q;
      n3  = n * n * n;
      a   = p2 - p0;
      b   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c   = -p0 + 3 * p1 - 3 * p2 + p3;
      num = 2 * p1 * n3 + a * i * n * n + b * i * i * n + c * i * i * i;
      den = 2 * n3;
      x   = num + n3;
      if (x >= 0) q = x / den;
      else q = -((-x + den - 1) / den);
      return saturate(q);
    endfunction

    function void queue_segment(xyz_t a, xyz_t b, xyz_t c, xyz_t d, int n);
      vertex_t v;
      int      i;
      for (i = 1; i <= n; i++) begin
        v.x         = spline_coord(a[0], b[0], c[0], d[0], i, n);
        v.y         = spline_coord(a[1], b[1], c[1], d[1], i, n);
        v.z         = spline_coord(a[2], b[2], c[2], d[2], i, n);
        v.run_end   = 1'b0;
        v.curve_end = 1'b0;
        enqueue_vertex(v);
      end
    endfunction

    function void note_point(coord_t x, coord_t y, coord_t z, logic fin);
      xyz_t    p;
      vertex_t v;
      int      n;
      int      before_cnt;
      p          = '{x, y, z};
      n          = int'(samples);
      if (n < 2) n = 2;
      if (n > MAX_SEG_SAMPLES) n = MAX_SEG_SAMPLES;
      before_cnt = expected_vertices.size();

      if (points_seen == 0) begin
        if (!fin) begin
          v = '{x, y, z, 1'b0, 1'b0};
          enqueue_vertex(v);
        end
      end else if (points_seen == 1) begin
        if (fin) queue_segment(window_pts[2], window_pts[2], p, p, n);
      end else begin
        // The first segment of a curve repeats its opening point as p0.
        queue_segment((points_seen >= 3) ? window_pts[0] : window_pts[1],
                      window_pts[1], window_pts[2], p, n);
        if (fin) queue_segment(window_pts[1], window_pts[2], p, p, n);
      end

      if (expected_vertices.size() > before_cnt) begin
        expected_vertices[expected_vertices.size() - 1].run_end = 1'b1;
        if (fin) expected_vertices[expected_vertices.size() - 1].curve_end = 1'b1;
      end

      if (fin) begin
        clear_window();
      end else begin
        window_pts[0] = window_pts[1];
        window_pts[1] = window_pts[2];
        window_pts[2] = p;
        if (points_seen < 3) points_seen++;
      end
    endfunction

    function void check_vertex(coord_t x, coord_t y, coord_t z, logic run_end,
                               logic curve_end);
      vertex_t want;
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex (%0d, %0d, %0d) run_end=%0b curve_end=%0b",
                   x, y, z, run_end, curve_end);
        return;
      end
      want = expected_vertices.pop_front();
      vertices_checked++;
      if (x !== want.x || y !== want.y || z !== want.z ||
          run_end !== want.run_end || curve_end !== want.curve_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("vertex %0d mismatch: expected (%0d, %0d, %0d) re=%0b ce=%0b",
                   vertices_checked, want.x, want.y, want.z, want.run_end,
                   want.curve_end);
          $display("                      got      (%0d, %0d, %0d) re=%0b ce=%0b",
                   x, y, z, run_end, curve_end);
        end
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  crst_pt_if  pt_if ();
  crst_vtx_if vtx_if ();

  catmull_rom_spline_tessellator_unit #(
    .MAX_SAMPLES (MAX_SEG_SAMPLES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pt_i        (pt_if),
    .vtx_o       (vtx_if)
  );

  spline_scoreboard sb;
  bit tx_idling;
  bit rx_idling;
  bit hold_off_req;
  int hold_offs_done = 0;
  int points_sent    = 0;
  int curves_sent    = 0;
  int idle_cycles    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3, 4: return coord_t'($urandom);
      default: return coord_t'($urandom_range(0, 2097151) - 1048576);
    endcase
  endfunction

  task automatic send_point(coord_t x, coord_t y, coord_t z, logic fin);
    int gap;
    pt_if.valid       <= 1'b1;
    pt_if.point_x     <= x;
    pt_if.point_y     <= y;
    pt_if.point_z     <= z;
    pt_if.final_point <= fin;
    do @(posedge clk_i); while (pt_if.ready !== 1'b1);
    sb.note_point(x, y, z, fin);
    points_sent++;
    if (tx_idling && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 9);
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_curve(int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_point(random_coord(), random_coord(), random_coord(), k == len - 1);
    end
    curves_sent++;
  endtask

  // The register may only change once the block has drained and gone idle.
  task automatic retune(logic [CfgW-1:0] value);
    pt_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_samples(value);
  endtask

  initial begin : stimulus
    int phase_samples [9];
    int phase_points [9];
    int p, k, len, sent, r;
    sb            = new();
    phase_samples = '{3, 2, 6, 1, 13, 32, 33, 5, 8};
    phase_points  = '{36, 32, 36, 20, 26, 8, 6, 36, 26};
    tx_idling     = 1'b1;
    rx_idling     = 1'b1;
    hold_off_req  = 1'b0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    pt_if.valid       <= 1'b0;
    pt_if.point_x     <= '0;
    pt_if.point_y     <= '0;
    pt_if.point_z     <= '0;
    pt_if.final_point <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset segment count first: a lone final point, then short curves at the limits.
    send_point(COORD_MAX, COORD_MIN, 32'sd0, 1'b1);
    send_point(32'sh0001_0000, -32'sh0001_0000, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 32'sh0000_0123, 1'b1);
    send_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, 32'sd0, COORD_MIN, 1'b1);
    for (k = 0; k < 5; k++) begin
      send_point(k[0] ? COORD_MIN : COORD_MAX, k[0] ? COORD_MAX : COORD_MIN,
                 coord_t'(k) - 32'sd2, k == 4);
    end
    curves_sent += 4;

    // Out-of-range register values clamp to the ends of the legal span.
    retune(6'd63);
    send_point(-32'sd1, 32'sd1, COORD_MAX, 1'b0);
    send_point(32'sd1, -32'sd1, COORD_MIN, 1'b1);
    curves_sent++;
    retune(6'd0);
    send_curve(4);

    for (p = 0; p < 9; p++) begin
      retune(CfgW'(phase_samples[p]));
      if (p == 0 || p == 4) hold_off_req = 1'b1;
      sent = 0;
      while (sent < phase_points[p]) begin
        if (p == 8) begin
          tx_idling = 1'b0;
          rx_idling = 1'b0;
        end else begin
          tx_idling = ($urandom_range(0, 3) != 0);
          rx_idling = ($urandom_range(0, 3) != 0);
        end
        r = $urandom_range(0, 99);
        if (r < 8) len = 1;
        else if (r < 20) len = 2;
        else if (r < 30) len = 3;
        else len = $urandom_range(4, 10);
        send_curve(len);
        sent += len;
      end
    end

    pt_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d control points in %0d curves and checked %0d vertices,",
             points_sent, curves_sent, sb.vertices_checked);
    $display("segment counts 2 to 32 incl. clamped register values, %0d long output hold-offs.",
             hold_offs_done);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : vertex_sink
    int stall_left;
    stall_left = 0;
    vtx_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        if (hold_off_req) begin
          stall_left   = HOLD_OFF_CYCLES;
          hold_off_req = 1'b0;
          hold_offs_done++;
        end else if (rx_idling && $urandom_range(0, 99) < 12) begin
          stall_left = $urandom_range(1, 9);
        end
      end
      if (stall_left > 0) begin
        vtx_if.ready <= 1'b0;
        stall_left--;
      end else begin
        vtx_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && vtx_if.valid === 1'b1 && vtx_if.ready === 1'b1)
      sb.check_vertex(vtx_if.out_x, vtx_if.out_y, vtx_if.out_z, vtx_if.run_end,
                      vtx_if.curve_end);
  end

  // Any word moving on either side counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((pt_if.valid === 1'b1 && pt_if.ready === 1'b1) ||
          (vtx_if.valid === 1'b1 && vtx_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no word accepted for %0d cycles", idle_cycles);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

endmodule

/* filelist.f */
hdl/crst_pkg.sv
hdl/crst_pt_if.sv
hdl/crst_vtx_if.sv
hdl/crst_div.sv
hdl/catmull_rom_spline_tessellator_unit.sv
bench/tb.sv
